/* hdl/modexp_pkg.sv */
package modexp_pkg;

   // fixed field widths
   localparam int MOD_W     = 32;
   localparam int EXP_W     = 64;
   localparam int PROD_W    = 2 * MOD_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   // modulus after reset
   localparam logic [MOD_W-1:0] MOD_RESET = {MOD_W{1'b1}};

   typedef struct packed {
      logic load;      // take a new request beat
      logic mul;       // form the next product
      logic div_step;  // one remainder bit
      logic wb;        // write remainder back to acc or run
      logic out_load;  // move acc into the response register
   } modexp_cmd_type;

   typedef struct packed {
      logic exp_zero;  // no exponent bits left to process
      logic div_last;  // final remainder bit this cycle
   } modexp_sts_type;

endpackage

/* hdl/modexp_dp.sv */
module modexp_dp #(
   parameter int EXP_BITS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [modexp_pkg::MOD_W-1:0]      csr_write_data,
   input  logic [modexp_pkg::MOD_W-1:0]      req_base,
   input  logic [modexp_pkg::EXP_W-1:0]      req_exponent,
   input  modexp_pkg::modexp_cmd_type        cmd,
   output modexp_pkg::modexp_sts_type        sts,
   output logic [modexp_pkg::MOD_W-1:0]      rsp_power
);
   import modexp_pkg::*;

   // divisor is one bit wider: a modulus of zero acts as 2^32
   logic [MOD_W:0]          div_ff;
   logic [MOD_W-1:0]        acc_ff;
   logic [MOD_W-1:0]        run_ff;
   logic [EXP_BITS-1:0]     exp_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [MOD_W-1:0]        rem_ff;
   logic [DIV_CNT_W-1:0]    cnt_ff;
   logic [MOD_W-1:0]        power_ff;

   logic [MOD_W-1:0]        op_a;
   logic [PROD_W-1:0]       prod_in;
   logic [MOD_W:0]          trial;
   logic [MOD_W:0]          diff;
   logic [MOD_W-1:0]        rem_in;

   // low exponent bit set: multiply acc, else square run
   assign op_a    = exp_ff[0] ? acc_ff : run_ff;
   assign prod_in = PROD_W'(op_a) * PROD_W'(run_ff);

   // restoring remainder, one dividend bit per cycle
   assign trial  = {rem_ff, prod_ff[PROD_W-1]};
   assign diff   = trial - div_ff;
   assign rem_in = (trial >= div_ff) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= {1'b0, MOD_RESET};
      end else if (csr_write_enable) begin
         div_ff <= {(csr_write_data == '0), csr_write_data};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff <= MOD_W'(1);
         run_ff <= req_base;
         exp_ff <= req_exponent[EXP_BITS-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.div_step) begin
         prod_ff <= prod_ff << 1;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.wb) begin
         if (exp_ff[0]) begin
            acc_ff <= rem_ff;
            exp_ff <= exp_ff & ~EXP_BITS'(1);
         end else begin
            run_ff <= rem_ff;
            exp_ff <= exp_ff >> 1;
         end
      end
      if (cmd.out_load) begin
         power_ff <= acc_ff;
      end
   end

   assign sts.exp_zero = (exp_ff == '0);
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(PROD_W - 1));
   assign rsp_power    = power_ff;

endmodule

/* hdl/modexp_ctrl.sv */
module modexp_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  modexp_pkg::modexp_sts_type   sts,
   output modexp_pkg::modexp_cmd_type   cmd
);
   import modexp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_WB,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (sts.exp_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_WB;
         end
         ST_WB: begin
            cmd.wb   = 1'b1;
            state_in = ST_STEP;
         end
         ST_DONE: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/modular_exponentiation.sv */
// channel   dir  handshake               payload
// req       in   req_valid / req_ready   req_base[31:0], req_exponent[63:0]
// rsp       out  rsp_valid / rsp_ready   rsp_power[31:0]
// csr       in   csr_write_enable        csr_write_data[31:0] (modulus)
//
// a request takes popcount(e) + msb(e) modular products,
// e being the low EXP_BITS of the exponent, msb(e) the index of its top set
// bit; exponent zero takes none. each modular product is a multiply step,
// the bit-serial remainder loop over the 64 product bits, and a write back.
// reset is synchronous; the modulus returns to 2^32-1, no response is pending.
// a finished result waits in the response register under rsp stall while the
// next request beat is already taken; the engine only holds if it finishes
// again before that response beat leaves.
module modular_exponentiation #(
   parameter int EXP_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   // modulus register
   input  logic                           csr_write_enable,
   input  logic [modexp_pkg::MOD_W-1:0]   csr_write_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [modexp_pkg::MOD_W-1:0]   req_base,
   input  logic [modexp_pkg::EXP_W-1:0]   req_exponent,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [modexp_pkg::MOD_W-1:0]   rsp_power
);
   import modexp_pkg::*;

   // commands from the sequencer, status back from the datapath
   modexp_cmd_type cmd;
   modexp_sts_type sts;

   // sequencer: load, then per exponent bit a multiply and/or a squaring,
   // each followed by the serial remainder, then hand off to the rsp register
   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: acc, running power, exponent shifter, 32x32 multiplier,
   // restoring remainder unit, modulus register and response register
   modexp_dp #(
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_power        (rsp_power)
   );

endmodule

/* hdl/modexp_checker.sv */
module modexp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [modexp_pkg::EXP_W-1:0]   req_exponent,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [modexp_pkg::MOD_W-1:0]   rsp_power
);
   import modexp_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power))
      else $error("response changed under stall");

   // one item at a time: busy right after a request beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a new response only comes out of a busy engine
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without work");

   // exponent zero gives one, after the step and done states
   a_exp_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && req_exponent == '0
      |=> ##2 rsp_valid && rsp_power == MOD_W'(1))
      else $error("exponent zero result wrong");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_exponent (req_exponent),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_power    (rsp_power)
);
